// ===== hdl/pcm_pkg.sv =====
// Shared types and constants of the PWM capture measurement block.
`default_nettype none
package pcm_pkg;

  localparam int unsigned CAPTURE_W = 16;
  localparam int unsigned CLOCK_W   = 27;
  localparam int unsigned FREQ_W    = 26;
  localparam int unsigned DUTY_W    = 7;
  localparam int unsigned HIGH_W    = 16;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register index of clock_hz, taken from the word address bit.
  localparam logic REG_CLOCK_HZ = 1'b0;

  localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET = 27'd8000000;

  typedef enum logic [1:0] {
    PH_RISE,
    PH_FALL,
    PH_NEXT_RISE
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_FREQ,
    ST_DIV_DUTY,
    ST_HOLD
  } state_e;

endpackage
`default_nettype wire

// ===== hdl/pcm_div.sv =====
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
`default_nettype none
module pcm_div #(
  parameter int unsigned DividendW = 27,
  parameter int unsigned DivisorW  = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DividendW-1:0] dividend_i,
  input  wire logic [DivisorW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [DividendW-1:0]      quotient_o
);

  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  dvs_q;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [DivisorW:0] rem_sh;
  logic [DivisorW:0] diff;
  logic              ge;

  // The partial remainder stays below the divisor, so the shifted value
  // fits in one bit more than the divisor.
  assign rem_sh = {rem_q, quo_q[DividendW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CntW'(DividendW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DivisorW-1:0] : rem_sh[DivisorW-1:0];
      quo_d = {quo_q[DividendW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== hdl/pwm_capture_measure.sv =====
// PWM frequency and duty measurement from a stream of capture timestamps.
// A rising or falling edge stamp is only stored and produces no result.
// The closing rising edge of a strictly increasing triple runs two 27-step
// divisions on the shared serial divider (frequency, then duty); any other
// triple skips the divider and gives an invalid result.
// Reset (asynchronous, active low) clears phase, FSM and output valid, and
// loads clock_hz with 8000000.
`default_nettype none
module pwm_capture_measure #(
  parameter int unsigned CounterBits = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // capture_time[15:0]
  input  wire logic [pcm_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // frequency_hz[25:0], duty_percent[32:26], high_ticks[48:33], zero fill
  output logic [pcm_pkg::OUT_DATA_W-1:0]         m_axis_tdata_o,
  // valid_res[0]
  output logic                                   m_axis_tuser_o,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  input  wire logic                              psel_i,
  input  wire logic                              penable_i,
  input  wire logic                              pwrite_i,
  input  wire logic [pcm_pkg::APB_ADDR_W-1:0]    paddr_i,
  input  wire logic [pcm_pkg::APB_DATA_W-1:0]    pwdata_i,
  output logic [pcm_pkg::APB_DATA_W-1:0]         prdata_o,
  output logic                                   pready_o
);
  import pcm_pkg::*;

  // Only the low counter bits of the 16-bit stamp take part.
  localparam int unsigned TimeW = (CounterBits < CAPTURE_W) ? CounterBits : CAPTURE_W;

  // Configuration register.
  logic [CLOCK_W-1:0] clock_hz_q;
  logic               cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i & (paddr_i[2] == REG_CLOCK_HZ);
  assign prdata_o = (paddr_i[2] == REG_CLOCK_HZ) ? APB_DATA_W'(clock_hz_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= CLOCK_HZ_RESET;
    end else if (cfg_wr) begin
      clock_hz_q <= pwdata_i[CLOCK_W-1:0];
    end
  end

  // Control state.
  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   out_valid_q, out_valid_d;

  // Payload.
  logic [TimeW-1:0]      rise_q, fall_q, high_q;
  logic [FREQ_W-1:0]     freq_q;
  logic [DUTY_W-1:0]     duty_q;
  logic                  ok_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_user_q;

  logic [TimeW-1:0]   t;
  logic [TimeW-1:0]   period_now;
  logic               ok_now;
  logic               out_load;
  logic               take_rise, take_fall, take_close;
  logic               freq_store, duty_store;
  logic               div_start;
  logic [CLOCK_W-1:0] div_dividend;
  logic [TimeW-1:0]   div_divisor;
  logic               div_done;
  logic [CLOCK_W-1:0] div_quotient;
  logic [CLOCK_W-1:0] high_x100;

  assign t          = s_axis_tdata_i[TimeW-1:0];
  assign period_now = t - rise_q;
  assign ok_now     = (rise_q < fall_q) && (fall_q < t);

  // high * 100 as shifts and adds; it fits well inside the dividend width.
  assign high_x100 = (CLOCK_W'(high_q) << 6) + (CLOCK_W'(high_q) << 5)
                   + (CLOCK_W'(high_q) << 2);

  always_comb begin
    state_d         = state_q;
    phase_d         = phase_q;
    out_valid_d     = out_valid_q;
    s_axis_tready_o = 1'b0;
    out_load        = 1'b0;
    take_rise       = 1'b0;
    take_fall       = 1'b0;
    take_close      = 1'b0;
    freq_store      = 1'b0;
    duty_store      = 1'b0;
    div_start       = 1'b0;
    div_dividend    = clock_hz_q;
    div_divisor     = period_now;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        // Ready is high throughout this state, so valid alone marks a transfer.
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          case (phase_q)
            PH_FALL: begin
              take_fall = 1'b1;
              phase_d   = PH_NEXT_RISE;
            end
            PH_NEXT_RISE: begin
              take_close = 1'b1;
              phase_d    = PH_RISE;
              if (ok_now) begin
                div_start = 1'b1;
                state_d   = ST_DIV_FREQ;
              end else begin
                state_d = ST_HOLD;
              end
            end
            default: begin
              take_rise = 1'b1;
              phase_d   = PH_FALL;
            end
          endcase
        end
      end
      ST_DIV_FREQ: begin
        if (div_done) begin
          freq_store   = 1'b1;
          div_start    = 1'b1;
          div_dividend = high_x100;
          div_divisor  = fall_q;
          state_d      = ST_DIV_DUTY;
        end
      end
      ST_DIV_DUTY: begin
        if (div_done) begin
          duty_store = 1'b1;
          state_d    = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_RISE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // On the closing edge the period is parked in fall_q, which is free then;
  // the next triple overwrites it before reading it.
  always_ff @(posedge clk_i) begin
    if (take_rise) begin
      rise_q <= t;
    end
    if (take_fall) begin
      fall_q <= t;
    end
    if (take_close) begin
      high_q <= fall_q - rise_q;
      fall_q <= period_now;
      ok_q   <= ok_now;
      freq_q <= '0;
      duty_q <= '0;
    end
    if (freq_store) begin
      freq_q <= div_quotient[FREQ_W-1:0];
    end
    if (duty_store) begin
      duty_q <= div_quotient[DUTY_W-1:0];
    end
    if (out_load) begin
      out_user_q <= ok_q;
      out_data_q <= {7'd0,
                     ok_q ? HIGH_W'(high_q) : HIGH_W'(0),
                     duty_q,
                     freq_q};
    end
  end

  pcm_div #(
    .DividendW(CLOCK_W),
    .DivisorW (TimeW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quotient)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule
`default_nettype wire
